// ----- src/pbc_pkg.sv -----
`timescale 1ns / 1ps

package pbc_pkg;

    localparam int COUNTER_BITS_DEF   = 16;
    localparam int INDEL_LEN_BITS_DEF = 10;

    localparam int KIND_W   = 2;
    localparam int SYM_W    = 8;
    localparam int READS_W  = 16;
    localparam int OUT_W    = 16;
    localparam int NUM_CNT  = 12;
    localparam int NUM_OUT  = 8;
    localparam int REF_W    = 3;
    localparam int RR_W     = READS_W + 1;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = NUM_OUT * OUT_W;
    localparam int OUT_USER_W = 2;

    localparam logic [KIND_W-1:0] KIND_HEADER = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CHAR   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END    = 2'd2;

    localparam logic [REF_W-1:0] REF_NONE = 3'd4;

    // A T C G N a t c g n . ,
    localparam logic [SYM_W-1:0] CNT_SYM [NUM_CNT] = '{
        8'h41, 8'h54, 8'h43, 8'h47, 8'h4E,
        8'h61, 8'h74, 8'h63, 8'h67, 8'h6E,
        8'h2E, 8'h2C
    };

    localparam int IDX_UPPER_N = 4;
    localparam int IDX_LOWER_A = 5;
    localparam int IDX_LOWER_N = 9;
    localparam int IDX_DOT     = 10;
    localparam int IDX_COMMA   = 11;

    localparam logic [SYM_W-1:0] SYM_DOLLAR = 8'h24;
    localparam logic [SYM_W-1:0] SYM_STAR   = 8'h2A;
    localparam logic [SYM_W-1:0] SYM_CARET  = 8'h5E;
    localparam logic [SYM_W-1:0] SYM_PLUS   = 8'h2B;
    localparam logic [SYM_W-1:0] SYM_MINUS  = 8'h2D;
    localparam logic [SYM_W-1:0] SYM_ZERO   = 8'h30;
    localparam logic [SYM_W-1:0] SYM_NINE   = 8'h39;

    localparam logic [RR_W-1:0] RR_MIN = 17'h10000;

endpackage

// ----- src/pileup_base_counter.sv -----
`timescale 1ns / 1ps

// channel   dir  handshake                      tdata (low bit up)          tuser
// s_axis    in   s_axis_tvalid / s_axis_tready  symbol[7:0] read_count     kind[1:0]
// m_axis    out  m_axis_tvalid / m_axis_tready  fwd_a fwd_t fwd_c fwd_g     sum_mismatch,
//                                               rev_a rev_t rev_c rev_g     n_seen
//
// one input transaction per cycle while s_axis_tready is high; the parse state and
// counters update in the accept cycle; a result leaves through a select/pair-add stage,
// a quad-add stage and a final add/compare output register
// synchronous active-low reset clears the parse state, counters and all valid flags
// s_axis_tready drops only when all three result stages are full and m_axis_tready is low

module pileup_base_counter #(
    parameter int COUNTER_BITS   = pbc_pkg::COUNTER_BITS_DEF,
    parameter int INDEL_LEN_BITS = pbc_pkg::INDEL_LEN_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // symbol[7:0], read_count[23:8]
    input  logic [pbc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // kind[1:0]
    input  logic [pbc_pkg::KIND_W-1:0]      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // fwd_a, fwd_t, fwd_c, fwd_g, rev_a, rev_t, rev_c, rev_g, 16 bits each
    output logic [pbc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // sum_mismatch[0], n_seen[1]
    output logic [pbc_pkg::OUT_USER_W-1:0]  m_axis_tuser
);

    localparam int CB    = COUNTER_BITS;
    localparam int LB    = INDEL_LEN_BITS;
    localparam int VW    = LB + 4;
    localparam int CMP_W = (CB + 3 > pbc_pkg::RR_W) ? CB + 3 : pbc_pkg::RR_W;
    localparam logic [LB-1:0] LMAX       = '1;
    localparam logic [LB-1:0] LMAX_DIV10 = LMAX / 10;

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_QUAL,
        MODE_LEN,
        MODE_SKIP
    } t_mode;

    typedef logic [pbc_pkg::NUM_OUT-1:0][pbc_pkg::OUT_W-1:0] t_res;

    // parse state
    t_mode                          r_mode, n_mode;
    logic [LB-1:0]                  r_skip, n_skip;
    logic [LB-1:0]                  r_acc, n_acc;
    logic [CB-1:0]                  r_cnt [pbc_pkg::NUM_CNT];
    logic [CB-1:0]                  n_cnt [pbc_pkg::NUM_CNT];
    logic [pbc_pkg::REF_W-1:0]      r_ref, n_ref;
    logic [pbc_pkg::RR_W-1:0]       r_rr, n_rr;
    logic                           r_active, n_active;

    // result pipeline
    logic                           r_s1_valid;
    t_res                           r_s1_res;
    logic [3:0][CB:0]               r_s1_pair;
    logic [pbc_pkg::RR_W-1:0]       r_s1_rr;
    logic                           r_s1_n;
    logic                           r_s2_valid;
    t_res                           r_s2_res;
    logic [1:0][CB+1:0]             r_s2_quad;
    logic [pbc_pkg::RR_W-1:0]       r_s2_rr;
    logic                           r_s2_n;
    logic                           r_o_valid;
    t_res                           r_o_res;
    logic                           r_o_mis;
    logic                           r_o_n;

    logic [pbc_pkg::KIND_W-1:0]     in_kind;
    logic [pbc_pkg::SYM_W-1:0]      in_sym;
    logic [pbc_pkg::READS_W-1:0]    in_reads;
    logic                           in_acc;
    logic                           emit;
    logic                           do_norm;
    logic                           clr_cnt;
    logic                           is_digit;
    logic [VW-1:0]                  len_next;
    logic [LB-1:0]                  skip_dec;
    logic [LB-1:0]                  acc_m1;
    logic [CB-1:0]                  sel [pbc_pkg::NUM_OUT];
    logic [CB+2:0]                  final_sum;
    logic                           o_free, s2_free, s1_free;

    assign in_sym   = s_axis_tdata[pbc_pkg::SYM_W-1:0];
    assign in_reads = s_axis_tdata[pbc_pkg::SYM_W +: pbc_pkg::READS_W];
    assign in_kind  = s_axis_tuser;
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign emit     = in_acc && (in_kind == pbc_pkg::KIND_END) && r_active;

    assign is_digit = (in_sym >= pbc_pkg::SYM_ZERO) && (in_sym <= pbc_pkg::SYM_NINE);
    assign len_next = (VW'(r_acc) << 3) + (VW'(r_acc) << 1) + VW'(in_sym[3:0]);
    assign skip_dec = (r_skip != '0) ? r_skip - 1'b1 : r_skip;
    assign acc_m1   = r_acc - 1'b1;

    always_comb begin
        n_mode   = r_mode;
        n_skip   = r_skip;
        n_acc    = r_acc;
        n_ref    = r_ref;
        n_rr     = r_rr;
        n_active = r_active;
        do_norm  = 1'b0;
        clr_cnt  = 1'b0;
        case (in_kind)
            pbc_pkg::KIND_HEADER: begin
                n_mode   = MODE_NORMAL;
                n_skip   = '0;
                n_acc    = '0;
                clr_cnt  = 1'b1;
                n_ref    = pbc_pkg::REF_NONE;
                for (int k = 0; k < 4; k++) begin
                    if (in_sym == pbc_pkg::CNT_SYM[k]) begin
                        n_ref = pbc_pkg::REF_W'(k);
                    end
                end
                n_rr     = {1'b0, in_reads};
                n_active = (in_reads != '0);
            end
            pbc_pkg::KIND_CHAR: begin
                if (r_active) begin
                    case (r_mode)
                        MODE_QUAL: begin
                            n_mode = MODE_NORMAL;
                        end
                        MODE_LEN: begin
                            if (is_digit) begin
                                if ((r_acc > LMAX_DIV10) || (len_next > VW'(LMAX))) begin
                                    n_acc = LMAX;
                                end else begin
                                    n_acc = len_next[LB-1:0];
                                end
                            end else if (r_acc == '0) begin
                                n_mode  = MODE_NORMAL;
                                do_norm = 1'b1;
                            end else begin
                                n_skip = acc_m1;
                                n_acc  = '0;
                                n_mode = (acc_m1 != '0) ? MODE_SKIP : MODE_NORMAL;
                            end
                        end
                        MODE_SKIP: begin
                            n_skip = skip_dec;
                            if (skip_dec == '0) begin
                                n_mode = MODE_NORMAL;
                            end
                        end
                        default: begin
                            do_norm = 1'b1;
                        end
                    endcase
                end
            end
            pbc_pkg::KIND_END: begin
                if (r_active) begin
                    n_active = 1'b0;
                    n_mode   = MODE_NORMAL;
                    n_skip   = '0;
                    n_acc    = '0;
                end
            end
            default: begin
            end
        endcase

        if (do_norm) begin
            if (in_sym == pbc_pkg::SYM_STAR) begin
                if (r_rr != pbc_pkg::RR_MIN) begin
                    n_rr = r_rr - 1'b1;
                end
            end else if (in_sym == pbc_pkg::SYM_CARET) begin
                n_mode = MODE_QUAL;
            end else if ((in_sym == pbc_pkg::SYM_PLUS) || (in_sym == pbc_pkg::SYM_MINUS)) begin
                n_mode = MODE_LEN;
                n_acc  = '0;
            end
        end

        for (int k = 0; k < pbc_pkg::NUM_CNT; k++) begin
            if (clr_cnt) begin
                n_cnt[k] = '0;
            end else if (do_norm && (in_sym == pbc_pkg::CNT_SYM[k]) && (r_cnt[k] != '1)) begin
                n_cnt[k] = r_cnt[k] + 1'b1;
            end else begin
                n_cnt[k] = r_cnt[k];
            end
        end
    end

    // reference base takes the dot and comma counts
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if (r_ref == pbc_pkg::REF_W'(k)) begin
                sel[k]     = r_cnt[pbc_pkg::IDX_DOT];
                sel[4 + k] = r_cnt[pbc_pkg::IDX_COMMA];
            end else begin
                sel[k]     = r_cnt[k];
                sel[4 + k] = r_cnt[pbc_pkg::IDX_LOWER_A + k];
            end
        end
    end

    assign o_free        = !r_o_valid || m_axis_tready;
    assign s2_free       = !r_s2_valid || o_free;
    assign s1_free       = !r_s1_valid || s2_free;
    assign s_axis_tready = s1_free;

    assign final_sum = (CB + 3)'(r_s2_quad[0]) + (CB + 3)'(r_s2_quad[1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_NORMAL;
            r_skip     <= '0;
            r_acc      <= '0;
            r_ref      <= pbc_pkg::REF_NONE;
            r_rr       <= '0;
            r_active   <= 1'b0;
            for (int k = 0; k < pbc_pkg::NUM_CNT; k++) begin
                r_cnt[k] <= '0;
            end
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (in_acc) begin
                r_mode   <= n_mode;
                r_skip   <= n_skip;
                r_acc    <= n_acc;
                r_ref    <= n_ref;
                r_rr     <= n_rr;
                r_active <= n_active;
                for (int k = 0; k < pbc_pkg::NUM_CNT; k++) begin
                    r_cnt[k] <= n_cnt[k];
                end
            end
            if (s1_free) begin
                r_s1_valid <= emit;
            end
            if (s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
            if (o_free) begin
                r_o_valid <= r_s2_valid;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            for (int k = 0; k < pbc_pkg::NUM_OUT; k++) begin
                r_s1_res[k] <= pbc_pkg::OUT_W'(sel[k]);
            end
            for (int k = 0; k < 4; k++) begin
                r_s1_pair[k] <= (CB + 1)'(sel[2 * k]) + (CB + 1)'(sel[2 * k + 1]);
            end
            r_s1_rr <= r_rr;
            r_s1_n  <= (r_cnt[pbc_pkg::IDX_UPPER_N] != '0) || (r_cnt[pbc_pkg::IDX_LOWER_N] != '0);
        end
        if (r_s1_valid && s2_free) begin
            r_s2_res     <= r_s1_res;
            r_s2_quad[0] <= (CB + 2)'(r_s1_pair[0]) + (CB + 2)'(r_s1_pair[1]);
            r_s2_quad[1] <= (CB + 2)'(r_s1_pair[2]) + (CB + 2)'(r_s1_pair[3]);
            r_s2_rr      <= r_s1_rr;
            r_s2_n       <= r_s1_n;
        end
        if (r_s2_valid && o_free) begin
            r_o_res <= r_s2_res;
            r_o_mis <= r_s2_rr[pbc_pkg::RR_W-1] ||
                       (CMP_W'(final_sum) != CMP_W'(r_s2_rr[pbc_pkg::READS_W-1:0]));
            r_o_n   <= r_s2_n;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_res;
    assign m_axis_tuser  = {r_o_n, r_o_mis};

endmodule

// ----- src/pbc_checker.sv -----
`timescale 1ns / 1ps

module pbc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [pbc_pkg::KIND_W-1:0]      s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [pbc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input logic [pbc_pkg::OUT_USER_W-1:0]  m_axis_tuser
);

    localparam int PEND_W = 8;

    logic [PEND_W-1:0] r_pend;
    logic              end_in;
    logic              res_out;

    assign end_in  = s_axis_tvalid && s_axis_tready && (s_axis_tuser == pbc_pkg::KIND_END);
    assign res_out = m_axis_tvalid && m_axis_tready;

    // upper bound on results still owed; sticks once full
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (r_pend != '1) begin
            if (end_in && !res_out) begin
                r_pend <= r_pend + 1'b1;
            end else if (!end_in && res_out && (r_pend != '0)) begin
                r_pend <= r_pend - 1'b1;
            end
        end
    end

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

    a_result_owed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_pend != '0)
        else $error("result without a preceding end transaction");

endmodule

bind pileup_base_counter pbc_checker u_pbc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
